### hdl/snc_pkg.sv
// ----------------------------------------------------------------------------
// snc_pkg: shared constants and helpers for the 8.3 short-name converter
// Character classes, name geometry and counter widths.
// ----------------------------------------------------------------------------
package snc_pkg;

  localparam int CHAR_W    = 8;
  // Name geometry: base bytes 0..7, extension bytes 8..10
  localparam int BASE_MAX  = 8;
  localparam int EXT_MAX   = 3;
  localparam int BASE_LEN  = 8;   // 1..BASE_MAX
  localparam int EXT_LEN   = 3;   // 1..EXT_MAX
  localparam int BASE_IDX_W = $clog2(BASE_MAX);
  localparam int EXT_IDX_W  = $clog2(EXT_MAX);
  localparam int BASE_CNT_W = $clog2(BASE_MAX + 1);
  localparam int EXT_CNT_W  = $clog2(EXT_MAX + 1);

  localparam logic [CHAR_W-1:0] PAD_CHAR  = 8'h20;  // space
  localparam logic [CHAR_W-1:0] DOT_CHAR  = 8'h2E;
  localparam logic [CHAR_W-1:0] NUL_CHAR  = 8'h00;
  localparam logic [CHAR_W-1:0] CASE_DIFF = 8'h20;  // 'a' - 'A'

  typedef logic [CHAR_W-1:0] char_t;

  // Fold a-z to A-Z, everything else passes
  function automatic char_t to_upper(input char_t c);
    char_t r;
    r = c;
    if (c >= "a" && c <= "z") begin
      r = c - CASE_DIFF;
    end
    return r;
  endfunction

  // Legal short-name characters (after upper-casing)
  function automatic logic allowed_char(input char_t c);
    logic ok;
    ok = 1'b0;
    if ((c >= "A" && c <= "Z") || (c >= "0" && c <= "9")) begin
      ok = 1'b1;
    end
    case (c)
      "_", "-", "$", "!", "#", "%", "&", "@", "^", "~": ok = 1'b1;
      default: ;
    endcase
    return ok;
  endfunction

endpackage

### hdl/snc_if.sv
// ----------------------------------------------------------------------------
// snc_if: valid/ready channel interfaces for the short-name converter
// One interface for character beats, one for finished-name beats.
// ----------------------------------------------------------------------------
interface snc_in_if;
  logic                 valid;
  logic                 ready;
  snc_pkg::char_t       char_code;
  logic                 last;

  modport source (output valid, char_code, last, input ready);
  modport sink   (input valid, char_code, last, output ready);
endinterface

interface snc_out_if;
  logic                 valid;
  logic                 ready;
  snc_pkg::char_t       base_byte0;
  snc_pkg::char_t       base_byte1;
  snc_pkg::char_t       base_byte2;
  snc_pkg::char_t       base_byte3;
  snc_pkg::char_t       base_byte4;
  snc_pkg::char_t       base_byte5;
  snc_pkg::char_t       base_byte6;
  snc_pkg::char_t       base_byte7;
  snc_pkg::char_t       ext_byte0;
  snc_pkg::char_t       ext_byte1;
  snc_pkg::char_t       ext_byte2;
  logic                 name_ok;

  modport source (output valid, base_byte0, base_byte1, base_byte2, base_byte3,
                  base_byte4, base_byte5, base_byte6, base_byte7,
                  ext_byte0, ext_byte1, ext_byte2, name_ok, input ready);
  modport sink   (input valid, base_byte0, base_byte1, base_byte2, base_byte3,
                  base_byte4, base_byte5, base_byte6, base_byte7,
                  ext_byte0, ext_byte1, ext_byte2, name_ok, output ready);
endinterface

### hdl/short_name_converter.sv
// ----------------------------------------------------------------------------
// short_name_converter: builds a space-padded 8.3 name from a character stream
// Upper-cases letters, checks the character set, splits base and extension
// at a single dot and reports the 11 name bytes and a valid flag on last.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                 beat completes
//  in_chan   in   char_code[7:0], last                    valid & ready
//  out_chan  out  base_byte0..7, ext_byte0..2, name_ok    valid & ready
//
//  One character beat per clock while in_chan.ready is high. The result of
//  a beat with last set appears in the output register on the next cycle;
//  the name state clears in the same edge, so the next component can start
//  right away. in_chan.ready drops only while a result is held and
//  out_chan.ready is low. Reset (rst_n low, synchronous) pads the name with
//  spaces and empties the output register.
// ----------------------------------------------------------------------------
module short_name_converter (
  input  logic        clk,
  input  logic        rst_n,
  snc_in_if.sink      in_chan,
  snc_out_if.source   out_chan
);

  // --------------------------------------------------------------------------
  // Name state
  snc_pkg::char_t                      base_r   [snc_pkg::BASE_MAX];
  snc_pkg::char_t                      ext_r    [snc_pkg::EXT_MAX];
  logic [snc_pkg::BASE_CNT_W-1:0]      base_cnt_r;
  logic [snc_pkg::EXT_CNT_W-1:0]       ext_cnt_r;
  logic                                in_ext_r;
  logic                                failed_r;

  snc_pkg::char_t                      base_nxt [snc_pkg::BASE_MAX];
  snc_pkg::char_t                      ext_nxt  [snc_pkg::EXT_MAX];
  logic [snc_pkg::BASE_CNT_W-1:0]      base_cnt_nxt;
  logic [snc_pkg::EXT_CNT_W-1:0]       ext_cnt_nxt;
  logic                                in_ext_nxt;
  logic                                failed_nxt;

  // Output register
  snc_pkg::char_t                      out_base_r [snc_pkg::BASE_MAX];
  snc_pkg::char_t                      out_ext_r  [snc_pkg::EXT_MAX];
  logic                                out_ok_r;
  logic                                out_valid_r;

  logic                                in_fire;
  logic                                out_fire;
  snc_pkg::char_t                      ch;
  logic                                ok_nxt;

  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_fire      = out_valid_r && out_chan.ready;
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign ch            = snc_pkg::to_upper(in_chan.char_code);

  // --------------------------------------------------------------------------
  // Character step: next name state for the incoming character
  always_comb begin
    base_nxt     = base_r;
    ext_nxt      = ext_r;
    base_cnt_nxt = base_cnt_r;
    ext_cnt_nxt  = ext_cnt_r;
    in_ext_nxt   = in_ext_r;
    failed_nxt   = failed_r;
    if (ch != snc_pkg::NUL_CHAR && !failed_r) begin
      if (ch == snc_pkg::DOT_CHAR) begin
        // leading dot or second dot kills the name
        if (in_ext_r || base_cnt_r == '0) begin
          failed_nxt = 1'b1;
        end else begin
          in_ext_nxt = 1'b1;
        end
      end else if (!snc_pkg::allowed_char(ch)) begin
        failed_nxt = 1'b1;
      end else if (!in_ext_r) begin
        if (base_cnt_r >= snc_pkg::BASE_CNT_W'(snc_pkg::BASE_LEN)) begin
          failed_nxt = 1'b1;
        end else begin
          for (int i = 0; i < snc_pkg::BASE_MAX; i++) begin
            if (base_cnt_r[snc_pkg::BASE_IDX_W-1:0] == snc_pkg::BASE_IDX_W'(i)) begin
              base_nxt[i] = ch;
            end
          end
          base_cnt_nxt = base_cnt_r + 1'b1;
        end
      end else begin
        if (ext_cnt_r >= snc_pkg::EXT_CNT_W'(snc_pkg::EXT_LEN)) begin
          failed_nxt = 1'b1;
        end else begin
          for (int i = 0; i < snc_pkg::EXT_MAX; i++) begin
            if (ext_cnt_r[snc_pkg::EXT_IDX_W-1:0] == snc_pkg::EXT_IDX_W'(i)) begin
              ext_nxt[i] = ch;
            end
          end
          ext_cnt_nxt = ext_cnt_r + 1'b1;
        end
      end
    end
    // valid: no failure, non-empty base, no dangling dot
    ok_nxt = !failed_nxt && (base_cnt_nxt != '0) && (!in_ext_nxt || ext_cnt_nxt != '0);
  end

  // --------------------------------------------------------------------------
  // Name state register; cleared after the last beat of a component
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_chan.last)) begin
      for (int i = 0; i < snc_pkg::BASE_MAX; i++) base_r[i] <= snc_pkg::PAD_CHAR;
      for (int i = 0; i < snc_pkg::EXT_MAX; i++)  ext_r[i]  <= snc_pkg::PAD_CHAR;
      base_cnt_r <= '0;
      ext_cnt_r  <= '0;
      in_ext_r   <= 1'b0;
      failed_r   <= 1'b0;
    end else if (in_fire) begin
      base_r     <= base_nxt;
      ext_r      <= ext_nxt;
      base_cnt_r <= base_cnt_nxt;
      ext_cnt_r  <= ext_cnt_nxt;
      in_ext_r   <= in_ext_nxt;
      failed_r   <= failed_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_chan.last) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_chan.last) begin
      out_base_r <= base_nxt;
      out_ext_r  <= ext_nxt;
      out_ok_r   <= ok_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.base_byte0 = out_base_r[0];
  assign out_chan.base_byte1 = out_base_r[1];
  assign out_chan.base_byte2 = out_base_r[2];
  assign out_chan.base_byte3 = out_base_r[3];
  assign out_chan.base_byte4 = out_base_r[4];
  assign out_chan.base_byte5 = out_base_r[5];
  assign out_chan.base_byte6 = out_base_r[6];
  assign out_chan.base_byte7 = out_base_r[7];
  assign out_chan.ext_byte0  = out_ext_r[0];
  assign out_chan.ext_byte1  = out_ext_r[1];
  assign out_chan.ext_byte2  = out_ext_r[2];
  assign out_chan.name_ok    = out_ok_r;

  // --------------------------------------------------------------------------
  // Assertions
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.last) |=> (base_cnt_r == '0 && ext_cnt_r == '0 &&
                                   !in_ext_r && !failed_r))
    else $error("name state not cleared after last beat");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.last) |=> out_valid_r)
    else $error("no result after last beat");

  a_base_bound: assert property (@(posedge clk) disable iff (!rst_n)
    base_cnt_r <= snc_pkg::BASE_CNT_W'(snc_pkg::BASE_LEN))
    else $error("base count past limit");

  a_ok_has_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ok_r) |-> (out_base_r[0] != snc_pkg::PAD_CHAR))
    else $error("valid name with empty base");

endmodule
